// ===== rtl/array_list_insert_delete_defines.svh =====
// Assertion macros for the ordered list engine checker.
// Depends on nothing; included by the checker file only.
`ifndef ARRAY_LIST_INSERT_DELETE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ALID_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ALID_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/alid_pkg.sv =====
// Package for the ordered list engine: opcodes, status codes, widths, cell control.
// No dependencies.
`timescale 1ns / 1ps

package alid_pkg;

   localparam int VALUE_W          = 32;
   localparam int POS_W            = 5;
   localparam int COUNT_OUT_W      = 6;
   localparam int DEFAULT_CAPACITY = 32;
   localparam int MAX_READ_CELLS   = 1 << POS_W;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_RANGE     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic             ins_en;
      logic             match_en;
      logic [POS_W-1:0] pos;
   } cell_ctl_type;

endpackage

// ===== rtl/array_list_insert_delete.sv =====
// Ordered list engine. Clear, insert and read: one beat in, result registered and valid in the
// next cycle, one item per cycle while the result is not stalled. Delete: cells capture match
// flags, then prefix-OR and shift down; the next item is held off until the shift is done.
// Synchronous reset clears the count and the handshake; entries keep their contents
// and are read only after being written, so no clearing pass is run.
`timescale 1ns / 1ps

module array_list_insert_delete #(
   parameter int CAPACITY = alid_pkg::DEFAULT_CAPACITY
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_op,
   input  logic signed [alid_pkg::VALUE_W-1:0]     req_value,
   input  logic [alid_pkg::POS_W-1:0]              req_position,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [alid_pkg::VALUE_W-1:0]     rsp_read_value,
   output logic [alid_pkg::COUNT_OUT_W-1:0]        rsp_entry_count,
   output logic [1:0]                              rsp_status
);
   import alid_pkg::*;

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
   localparam int RD_N  = (CAPACITY < MAX_READ_CELLS) ? CAPACITY : MAX_READ_CELLS;

   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      del_busy_ff, del_busy_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rd_ff, rd_in;
   logic [COUNT_OUT_W-1:0]    cnt_out_ff;
   status_type                status_ff, status_in;

   logic                      accept;
   op_type                    op;
   logic                      full;
   logic                      pos_past_cnt;
   logic                      pos_in_list;
   logic                      found;
   logic                      rsp_load;
   logic signed [VALUE_W-1:0] rd_mux;
   cell_ctl_type              ctl;

   logic signed [VALUE_W-1:0] ent   [CAPACITY];
   logic [CAPACITY-1:0]       match;
   logic [CAPACITY-1:0]       seen;

   assign req_stall = del_busy_ff | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign op        = op_type'(req_op);

   assign full         = (cnt_ff == CW'(CAPACITY));
   assign pos_past_cnt = (CMP_W'(req_position) >  CMP_W'(cnt_ff));
   assign pos_in_list  = (CMP_W'(req_position) <  CMP_W'(cnt_ff));
   assign found        = seen[CAPACITY-1];

   assign ctl.ins_en   = accept && (op == OP_INSERT) && !full && !pos_past_cnt;
   assign ctl.match_en = accept && (op == OP_DELETE);
   assign ctl.pos      = req_position;

   // Row of cells; each takes from its lower neighbor on insert, upper on delete.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] lower_data;
      logic signed [VALUE_W-1:0] upper_data;
      if (i == 0) begin : g_lo
         assign lower_data = req_value;
      end else begin : g_lo_n
         assign lower_data = ent[i-1];
      end
      if (i == CAPACITY - 1) begin : g_hi
         assign upper_data = ent[i];
      end else begin : g_hi_n
         assign upper_data = ent[i+1];
      end
      alid_cell #(
         .INDEX (i),
         .CNT_W (CW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cnt        (cnt_ff),
         .value      (req_value),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .shift_down (del_busy_ff & seen[i]),
         .entry      (ent[i]),
         .match      (match[i])
      );
   end

   alid_prefix #(
      .N (CAPACITY)
   ) u_prefix (
      .match (match),
      .seen  (seen)
   );

   always_comb begin
      rd_mux = '0;
      for (int i = 0; i < RD_N; i++) begin
         if (req_position == POS_W'(i)) begin
            rd_mux = ent[i];
         end
      end
   end

   always_comb begin
      cnt_in      = cnt_ff;
      del_busy_in = 1'b0;
      rd_in       = '0;
      status_in   = ST_OK;
      if (del_busy_ff) begin
         if (found) begin
            cnt_in = cnt_ff - CW'(1);
         end else begin
            status_in = ST_NOT_FOUND;
         end
      end else if (accept) begin
         unique case (op)
            OP_CLEAR: begin
               cnt_in = '0;
            end
            OP_INSERT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else if (pos_past_cnt) begin
                  status_in = ST_RANGE;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
            OP_DELETE: begin
               del_busy_in = 1'b1;
            end
            OP_READ: begin
               if (pos_in_list) begin
                  rd_in = rd_mux;
               end else begin
                  status_in = ST_RANGE;
               end
            end
         endcase
      end
   end

   assign rsp_load     = del_busy_ff | (accept & (op != OP_DELETE));
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         del_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         del_busy_ff  <= del_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result beat until taken.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rd_ff      <= rd_in;
         cnt_out_ff <= COUNT_OUT_W'(cnt_in);
         status_ff  <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rd_ff;
   assign rsp_entry_count = cnt_out_ff;
   assign rsp_status      = status_ff;

endmodule

// ===== rtl/alid_cell.sv =====
// One list cell: holds one entry, shifts up on insert, down on delete, flags a match.
// Depends on alid_pkg.
`timescale 1ns / 1ps

module alid_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 6
) (
   input  logic                                clock,
   input  alid_pkg::cell_ctl_type              ctl,
   input  logic [CNT_W-1:0]                    cnt,
   input  logic signed [alid_pkg::VALUE_W-1:0] value,
   input  logic signed [alid_pkg::VALUE_W-1:0] lower_data,
   input  logic signed [alid_pkg::VALUE_W-1:0] upper_data,
   input  logic                                shift_down,
   output logic signed [alid_pkg::VALUE_W-1:0] entry,
   output logic                                match
);
   import alid_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic                      match_ff;
   logic                      at_pos;
   logic                      above_pos;
   logic                      live;

   assign at_pos    = (32'(INDEX) == 32'(ctl.pos));
   assign above_pos = (32'(INDEX) >  32'(ctl.pos));
   assign live      = (32'(INDEX) <  32'(cnt));

   always_ff @(posedge clock) begin
      if (ctl.ins_en) begin
         if (at_pos) begin
            entry_ff <= value;
         end else if (above_pos) begin
            entry_ff <= lower_data;
         end
      end else if (shift_down) begin
         entry_ff <= upper_data;
      end
      if (ctl.match_en) begin
         match_ff <= live && (entry_ff == value);
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== rtl/alid_prefix.sv =====
// Inclusive prefix OR over the cell match flags, log-depth.
// Depends on nothing.
`timescale 1ns / 1ps

module alid_prefix #(
   parameter int N = 32
) (
   input  logic [N-1:0] match,
   output logic [N-1:0] seen
);
   localparam int LV = (N > 1) ? $clog2(N) : 1;

   logic [N-1:0] lvl [LV+1];

   assign lvl[0] = match;

   for (genvar l = 0; l < LV; l++) begin : g_lvl
      for (genvar i = 0; i < N; i++) begin : g_bit
         if (i >= (1 << l)) begin : g_or
            assign lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
         end else begin : g_pass
            assign lvl[l+1][i] = lvl[l][i];
         end
      end
   end

   assign seen = lvl[LV];

endmodule

// ===== rtl/alid_checker.sv =====
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on alid_pkg and array_list_insert_delete_defines.svh.
`timescale 1ns / 1ps
`include "array_list_insert_delete_defines.svh"

module alid_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [1:0]                          req_op,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [alid_pkg::VALUE_W-1:0] rsp_read_value,
   input logic [1:0]                          rsp_status
);
   import alid_pkg::*;

   `ALID_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "result beat right after reset")
   `ALID_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "stalled result dropped")
   `ALID_ASSERT(a_fast_ops, req_valid && !req_stall && req_op != OP_DELETE |=> rsp_valid, "no result")
   `ALID_ASSERT(a_zero_on_err, rsp_valid && rsp_status != ST_OK |-> rsp_read_value == 0, "nonzero read value on error")

endmodule

bind array_list_insert_delete alid_checker u_alid_checker (.*);
